// ===== hw/rtl/particle_pool_update_unit_macros.svh =====
// Assertion macros for the particle pool update unit.
// Used by files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef PARTICLE_POOL_UPDATE_UNIT_MACROS_SVH
`define PARTICLE_POOL_UPDATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ppu assertion failed");
`define PPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppu implication failed");
`else
`define PPU_ASSERT(lbl, prop)
`define PPU_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ppu_pkg.sv =====
// Types, states and arithmetic helpers for the particle pool update unit.
// No dependencies.
package ppu_pkg;

	typedef enum logic [1:0] {
		REQ_SPAWN = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE,
		ST_SRD, ST_SCK, ST_SMX, ST_SMY, ST_SWR,
		ST_TRD, ST_TMX, ST_TMY, ST_TWR,
		ST_RRD, ST_RDT, ST_OUT
	} state_t;

	// one pool slot as held in memory
	typedef struct packed {
		logic        [16:0] life;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic        [8:0]  grey;
		logic        [16:0] alpha;
	} rec_t;

	localparam int unsigned REC_W   = $bits(rec_t);
	localparam logic [16:0] FULL_Q16 = 17'h10000;
	localparam logic signed [16:0] VEL_SCALE = 17'sd6554;

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		if (v > 19'sd32767)
			return 16'sh7fff;
		else if (v < -19'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	// floor((code-50)*16/10) = floor(code*16/10) - 80; /10 by reciprocal 6554/2^16
	function automatic logic signed [18:0] jitter(input logic [6:0] code);
		logic [23:0] p;
		p = {13'd0, code, 4'd0} * 24'd6554;
		return $signed({11'd0, p[23:16]}) - 19'sd80;
	endfunction

	// 128 + floor(code*256/100); /100 via 5243/2^19
	function automatic logic [8:0] grey_of(input logic [6:0] code);
		logic [19:0] p;
		logic [9:0]  g;
		p = {13'd0, code} * 20'd5243;
		g = 10'd128 + p[19:11];
		return g[8:0];
	endfunction

endpackage

// ===== hw/rtl/ppu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppu_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/particle_pool_update_unit.sv =====
// Particle pool update unit: spawn, tick and read over a pool held in one RAM.
// Spawn scans on from the last spawned slot for a free one, tick rewrites every slot,
// read loads one slot (none beyond the pool); shared 17x17 multiplier and RAM port.
// A new request is taken only in idle, once the last result is in the output register.
// Reset: asynchronous, active low; then a clearing pass over every slot zeroes the
// pool while no beat is accepted.
`include "particle_pool_update_unit_macros.svh"
module particle_pool_update_unit #(
	parameter int POOL_SIZE = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [15:0]        dt,
	input  logic signed [15:0] obj_pos_x,
	input  logic signed [15:0] obj_pos_y,
	input  logic signed [15:0] obj_vel_x,
	input  logic signed [15:0] obj_vel_y,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	input  logic [6:0]         jitter_code,
	input  logic [6:0]         grey_code,
	input  logic [8:0]         slot_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [8:0]         slot,
	output logic               alive,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [8:0]         grey,
	output logic [16:0]        alpha,
	output logic [16:0]        life
);
	import ppu_pkg::*;

	localparam int AW = $clog2(POOL_SIZE);
	localparam logic [AW-1:0] LAST = AW'(POOL_SIZE - 1);

	state_t state_q, state_d;

	// captured request
	logic [1:0]         req_q;
	logic [15:0]        dt_q;
	logic signed [15:0] opx_q, opy_q, ovx_q, ovy_q, offx_q, offy_q;
	logic [6:0]         jcode_q, gcode_q;

	logic [AW-1:0] idx_q, cnt_q, slot_q, hint_q;
	logic signed [17:0] dx_q, dy_q;
	rec_t rec_q;

	logic [8:0] res_slot_q, out_slot_q;
	rec_t       res_rec_q, out_rec_q;
	logic       out_valid_q;

	// RAM port
	logic          we_c;
	logic [AW-1:0] waddr_c;
	rec_t          wdata_c, rd_rec;
	logic [REC_W-1:0] rdata_w;

	ppu_ram #(.W(REC_W), .D(POOL_SIZE)) u_ram (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(wdata_c),
		.raddr(idx_q),
		.rdata(rdata_w)
	);
	assign rd_rec = rec_t'(rdata_w);

	wire accept   = in_valid && !in_stall;
	wire out_free = !out_valid_q || !out_stall;
	wire in_range = 32'(slot_index) < POOL_SIZE;

	// shared multiplier: velocity times dt on ticks, times 0.1 on spawns
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod_c;
	always_comb begin
		mul_a = {ovx_q[15], ovx_q};
		mul_b = VEL_SCALE;
		case (state_q)
			ST_TMX: begin
				mul_a = {rd_rec.vel_x[15], rd_rec.vel_x};
				mul_b = $signed({1'b0, dt_q});
			end
			ST_TMY: begin
				mul_a = {rec_q.vel_y[15], rec_q.vel_y};
				mul_b = $signed({1'b0, dt_q});
			end
			ST_SMY: mul_a = {ovy_q[15], ovy_q};
			default: mul_a = {ovx_q[15], ovx_q};
		endcase
	end
	assign prod_c = mul_a * mul_b;

	// tick update of the slot held in rec_q
	logic [16:0] life_new;
	logic [18:0] fade5;
	logic [17:0] fade;
	rec_t        tick_rec, spawn_rec;
	always_comb begin
		life_new = (rec_q.life > {1'b0, dt_q}) ? rec_q.life - {1'b0, dt_q} : 17'd0;
		fade5    = 19'(dt_q) * 19'd5;
		fade     = fade5[18:1];
		tick_rec = rec_q;
		tick_rec.life = life_new;
		if (life_new != 17'd0) begin
			tick_rec.pos_x = sat16(19'(rec_q.pos_x) - 19'(dx_q));
			tick_rec.pos_y = sat16(19'(rec_q.pos_y) - 19'(dy_q));
			tick_rec.alpha = ({1'b0, rec_q.alpha} > fade) ?
				17'({1'b0, rec_q.alpha} - fade) : 17'd0;
		end
	end

	always_comb begin
		spawn_rec.life  = FULL_Q16;
		spawn_rec.alpha = FULL_Q16;
		spawn_rec.pos_x = sat16(19'(opx_q) + jitter(jcode_q) + 19'(offx_q));
		spawn_rec.pos_y = sat16(19'(opy_q) + jitter(jcode_q) + 19'(offy_q));
		spawn_rec.vel_x = dx_q[15:0];
		spawn_rec.vel_y = dy_q[15:0];
		spawn_rec.grey  = grey_of(gcode_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:  if (idx_q == LAST) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (req_t'(req_type))
						REQ_SPAWN: state_d = ST_SRD;
						REQ_TICK:  state_d = ST_TRD;
						REQ_READ:  state_d = in_range ? ST_RRD : ST_OUT;
						default:   state_d = ST_OUT;
					endcase
				end
			end
			ST_SRD: state_d = ST_SCK;
			ST_SCK: begin
				if (rd_rec.life == 17'd0 || cnt_q == LAST)
					state_d = ST_SMX;
				else
					state_d = ST_SRD;
			end
			ST_SMX: state_d = ST_SMY;
			ST_SMY: state_d = ST_SWR;
			ST_SWR: state_d = ST_OUT;
			ST_TRD: state_d = ST_TMX;
			ST_TMX: state_d = ST_TMY;
			ST_TMY: state_d = ST_TWR;
			ST_TWR: state_d = (idx_q == LAST) ? ST_OUT : ST_TRD;
			ST_RRD: state_d = ST_RDT;
			ST_RDT: state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM write and handshake outputs
	always_comb begin
		we_c    = 1'b0;
		waddr_c = idx_q;
		wdata_c = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLR: we_c = 1'b1;
			ST_IDLE: in_stall = 1'b0;
			ST_SWR: begin
				we_c    = 1'b1;
				waddr_c = slot_q;
				wdata_c = spawn_rec;
			end
			ST_TWR: begin
				we_c    = 1'b1;
				wdata_c = tick_rec;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			idx_q       <= '0;
			cnt_q       <= '0;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// load a new beat when the register is free, else drop the one taken
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req_t'(req_type) == REQ_SPAWN)
							idx_q <= hint_q;
						else if (req_t'(req_type) == REQ_READ && in_range)
							idx_q <= AW'(slot_index);
						else
							idx_q <= '0;
					end
				end
				ST_SCK: begin
					if (rd_rec.life != 17'd0 && cnt_q != LAST) begin
						idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SWR: hint_q <= slot_q;
				ST_TWR: if (idx_q != LAST) idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q   <= req_type;
					dt_q    <= dt;
					opx_q   <= obj_pos_x;
					opy_q   <= obj_pos_y;
					ovx_q   <= obj_vel_x;
					ovy_q   <= obj_vel_y;
					offx_q  <= offset_x;
					offy_q  <= offset_y;
					jcode_q <= jitter_code;
					gcode_q <= grey_code;
					// results for requests that touch no slot
					res_rec_q  <= '0;
					res_slot_q <= (req_t'(req_type) == REQ_READ) ? slot_index : 9'd0;
				end
			end
			ST_SCK: begin
				if (rd_rec.life == 17'd0)
					slot_q <= idx_q;
				else if (cnt_q == LAST)
					slot_q <= '0;
			end
			ST_SMX, ST_TMX: dx_q <= prod_c[33:16];
			ST_SMY, ST_TMY: dy_q <= prod_c[33:16];
			ST_SWR: begin
				res_rec_q  <= spawn_rec;
				res_slot_q <= 9'(slot_q);
			end
			ST_RDT: res_rec_q <= rd_rec;
			ST_OUT: begin
				if (out_free) begin
					out_rec_q  <= res_rec_q;
					out_slot_q <= res_slot_q;
				end
			end
			default: ;
		endcase
		if (state_q == ST_TMX)
			rec_q <= rd_rec;
	end

	assign out_valid = out_valid_q;
	assign slot      = out_slot_q;
	assign alive     = out_rec_q.life != 17'd0;
	assign pos_x     = out_rec_q.pos_x;
	assign pos_y     = out_rec_q.pos_y;
	assign grey      = out_rec_q.grey;
	assign alpha     = out_rec_q.alpha;
	assign life      = out_rec_q.life;

	`PPU_ASSERT_IMP(a_we_busy, we_c, state_q != ST_IDLE && state_q != ST_OUT)
	`PPU_ASSERT(a_hint_range, 32'(hint_q) < POOL_SIZE)
	`PPU_ASSERT_IMP(a_swr_out, state_q == ST_SWR, ##1 state_q == ST_OUT)
	`PPU_ASSERT_IMP(a_out_from_out, $rose(out_valid_q), $past(state_q == ST_OUT))
	`PPU_ASSERT_IMP(a_req_used, state_q == ST_TWR, req_t'(req_q) == REQ_TICK)
endmodule

// ===== sim/particle_pool_update_checker.sv =====
// Scoreboard for the particle pool update unit: keeps its own pool copy,
// predicts each result beat and compares it. Depends on ppu_pkg only.
`timescale 1ns / 1ps
module particle_pool_update_checker #(
	parameter int POOL_SIZE = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [15:0]        dt,
	input  logic signed [15:0] obj_pos_x,
	input  logic signed [15:0] obj_pos_y,
	input  logic signed [15:0] obj_vel_x,
	input  logic signed [15:0] obj_vel_y,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	input  logic [6:0]         jitter_code,
	input  logic [6:0]         grey_code,
	input  logic [8:0]         slot_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [8:0]         slot,
	input  logic               alive,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [8:0]         grey,
	input  logic [16:0]        alpha,
	input  logic [16:0]        life,
	output int                 fail_count,
	output int                 pending
);
	import ppu_pkg::*;

	typedef struct packed {
		logic [8:0]  slot;
		logic        alive;
		logic [15:0] px;
		logic [15:0] py;
		logic [8:0]  grey;
		logic [16:0] alpha;
		logic [16:0] life;
	} slot_view_t;

	slot_view_t         slot_view_q[$];
	logic [16:0]        life_m [POOL_SIZE];
	logic signed [15:0] px_m [POOL_SIZE];
	logic signed [15:0] py_m [POOL_SIZE];
	logic signed [15:0] vx_m [POOL_SIZE];
	logic signed [15:0] vy_m [POOL_SIZE];
	logic [8:0]         grey_m [POOL_SIZE];
	logic [16:0]        alpha_m [POOL_SIZE];
	int unsigned        hint;

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint floor_div10(input longint v);
		if (v >= 0)
			return v / 10;
		return -((-v + 9) / 10);
	endfunction

	function automatic slot_view_t view_of(input int unsigned s, input bit ok);
		slot_view_t v;
		v = '0;
		v.slot = s[8:0];
		if (ok) begin
			v.alive = life_m[s] != 0;
			v.px    = px_m[s];
			v.py    = py_m[s];
			v.grey  = grey_m[s];
			v.alpha = alpha_m[s];
			v.life  = life_m[s];
		end
		return v;
	endfunction

	function automatic void clear_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			life_m[i] = '0; px_m[i] = '0; py_m[i] = '0; vx_m[i] = '0;
			vy_m[i] = '0; grey_m[i] = '0; alpha_m[i] = '0;
		end
		hint = 0;
	endfunction

	// update the pool copy for one accepted request, return the result it gives
	function automatic slot_view_t apply_request();
		int unsigned s;
		int unsigned h;
		bit          found;
		longint      jit;
		longint      dtl;
		logic [31:0] fade;
		logic [16:0] l;
		longint      dx;
		longint      dy;
		s = 0;
		found = 0;
		dtl = dt;
		case (req_type)
			REQ_SPAWN: begin
				h = hint < POOL_SIZE ? hint : 0;
				for (int i = h; i < POOL_SIZE && !found; i++)
					if (life_m[i] == 0) begin s = i; found = 1; end
				for (int i = 0; i < h && !found; i++)
					if (life_m[i] == 0) begin s = i; found = 1; end
				hint = s;
				jit = floor_div10((longint'(jitter_code) - 50) * 16);
				px_m[s] = clamp16(longint'(obj_pos_x) + jit + longint'(offset_x));
				py_m[s] = clamp16(longint'(obj_pos_y) + jit + longint'(offset_y));
				vx_m[s] = 16'((longint'(obj_vel_x) * 6554) >>> 16);
				vy_m[s] = 16'((longint'(obj_vel_y) * 6554) >>> 16);
				grey_m[s] = 9'(128 + (int'(grey_code) * 256) / 100);
				alpha_m[s] = FULL_Q16;
				life_m[s] = FULL_Q16;
				return view_of(s, 1);
			end
			REQ_TICK: begin
				fade = (32'(dt) * 5) >> 1;
				for (int i = 0; i < POOL_SIZE; i++) begin
					l = life_m[i] > dt ? life_m[i] - dt : '0;
					life_m[i] = l;
					if (l != 0) begin
						dx = (longint'(vx_m[i]) * dtl) >>> 16;
						dy = (longint'(vy_m[i]) * dtl) >>> 16;
						px_m[i] = clamp16(longint'(px_m[i]) - dx);
						py_m[i] = clamp16(longint'(py_m[i]) - dy);
						alpha_m[i] = alpha_m[i] > fade ? 17'(alpha_m[i] - fade) : '0;
					end
				end
				return view_of(0, 0);
			end
			REQ_READ:
				return view_of(slot_index, slot_index < POOL_SIZE);
			default:
				return view_of(0, 0);
		endcase
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		clear_pool();
	end

	always @(posedge clk or negedge arst_n) begin
		slot_view_t got;
		slot_view_t want;
		if (!arst_n) begin
			clear_pool();
			slot_view_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {slot, alive, pos_x, pos_y, grey, alpha, life};
				if (slot_view_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: slot %0d", slot);
				end else begin
					want = slot_view_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("beat differs: exp slot %0d alive %0d x %0d y %0d %s",
								want.slot, want.alive, $signed(want.px),
								$signed(want.py), "");
							$display("  exp grey %0d a %0d l %0d",
								want.grey, want.alpha, want.life);
							$display("  got slot %0d alive %0d x %0d y %0d",
								got.slot, got.alive, $signed(got.px), $signed(got.py));
							$display("  got grey %0d a %0d l %0d",
								got.grey, got.alpha, got.life);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				slot_view_q = {slot_view_q, apply_request()};
			pending = slot_view_q.size();
		end
	end
endmodule

// ===== sim/particle_pool_update_unit_tb.sv =====
// Top of the particle pool update unit bench: clock, reset, request stimulus
// and verdict. Depends on ppu_pkg, the unit itself and particle_pool_update_checker.
`timescale 1ns / 1ps
module particle_pool_update_unit_tb;
	import ppu_pkg::*;

	localparam int POOL_SIZE = 512;
	// longest quiet stretch: a full tick plus the clearing pass, with margin
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] dt;
		logic [15:0] opx, opy, ovx, ovy, ofx, ofy;
		logic [6:0]  jc, gc;
		logic [8:0]  idx;
	} pool_req_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [15:0]        dt;
	logic signed [15:0] obj_pos_x, obj_pos_y, obj_vel_x, obj_vel_y;
	logic signed [15:0] offset_x, offset_y;
	logic [6:0]         jitter_code, grey_code;
	logic [8:0]         slot_index;
	logic               out_valid;
	logic               out_stall;
	logic [8:0]         slot;
	logic               alive;
	logic signed [15:0] pos_x, pos_y;
	logic [8:0]         grey;
	logic [16:0]        alpha, life;
	int                 fail_count;
	int                 pending;

	bit quiet;       // no idling on either side when set
	int quiet_cycles;
	int stall_left;

	particle_pool_update_unit #(.POOL_SIZE(POOL_SIZE)) uut (.*);
	particle_pool_update_checker #(.POOL_SIZE(POOL_SIZE)) checker_i (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// result side backpressure: random stall bursts
	always @(negedge clk) begin
		if (quiet) begin
			out_stall = 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall = 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 12);
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// watchdog on cycles with no beat moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("particle_pool_update_unit: mismatch");
			$finish;
		end
	end

	// drive one request beat at the falling edge, hold it until accepted
	task automatic send_req(input pool_req_t r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid    = 1'b1;
		req_type    = r.kind;
		dt          = r.dt;
		obj_pos_x   = r.opx;
		obj_pos_y   = r.opy;
		obj_vel_x   = r.ovx;
		obj_vel_y   = r.ovy;
		offset_x    = r.ofx;
		offset_y    = r.ofy;
		jitter_code = r.jc;
		grey_code   = r.gc;
		slot_index  = r.idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// random request of a given kind; unused fields still get random content
	function automatic pool_req_t rand_req(input logic [1:0] kind);
		pool_req_t r;
		r.kind = kind;
		r.dt   = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2500));
		r.opx  = 16'($urandom); r.opy = 16'($urandom);
		r.ovx  = 16'($urandom); r.ovy = 16'($urandom);
		r.ofx  = 16'($urandom); r.ofy = 16'($urandom);
		// codes above 99 now and then
		r.jc   = $urandom_range(0, 7) == 0 ? 7'($urandom) : 7'($urandom_range(0, 99));
		r.gc   = $urandom_range(0, 7) == 0 ? 7'($urandom) : 7'($urandom_range(0, 99));
		r.idx  = 9'($urandom_range(0, POOL_SIZE - 1));
		return r;
	endfunction

	function automatic logic [1:0] rand_kind();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return REQ_SPAWN;
		if (p < 57) return REQ_TICK;
		if (p < 95) return REQ_READ;
		return REQ_NONE;
	endfunction

	task automatic send_kind(input logic [1:0] kind);
		send_req(rand_req(kind));
	endtask

	initial begin
		pool_req_t r;
		int        waited;
		quiet = 1'b0;
		quiet_cycles = 0;
		stall_left = 0;
		out_stall = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_NONE;
		dt = '0;
		obj_pos_x = '0; obj_pos_y = '0; obj_vel_x = '0; obj_vel_y = '0;
		offset_x = '0; offset_y = '0;
		jitter_code = '0; grey_code = '0; slot_index = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: saturating sums, code extremes, velocity extremes
		r = rand_req(REQ_SPAWN);
		r.opx = 16'sh7fff; r.opy = 16'sh8000; r.ofx = 16'sh7fff; r.ofy = 16'sh8000;
		r.ovx = 16'sh8000; r.ovy = 16'sh7fff; r.jc = 7'd99; r.gc = 7'd99;
		send_req(r);
		r.opx = 16'sh8000; r.opy = 16'sh7fff; r.ofx = 16'sh8000; r.ofy = 16'sh7fff;
		r.ovx = 16'sh7fff; r.ovy = 16'sh8000; r.jc = 7'd0; r.gc = 7'd0;
		send_req(r);
		r.opx = '0; r.opy = '0; r.ofx = '0; r.ofy = '0; r.ovx = -16'sd1; r.ovy = 16'sd1;
		r.jc = 7'd127; r.gc = 7'd127;
		send_req(r);
		r.jc = 7'd50; r.gc = 7'd100;
		send_req(r);
		r = rand_req(REQ_READ); r.idx = 9'd0; send_req(r);
		r.idx = 9'd3; send_req(r);
		r.idx = 9'(POOL_SIZE - 1); send_req(r);
		r = rand_req(REQ_TICK); r.dt = 16'd0; send_req(r);
		r.dt = 16'd1000; send_req(r);
		r = rand_req(REQ_READ); r.idx = 9'd1; send_req(r);
		r = rand_req(REQ_NONE); send_req(r);
		// life ends at zero: after the tick of 1000, 65535 empties the slots; then one more
		r = rand_req(REQ_TICK); r.dt = 16'hffff; send_req(r);
		r = rand_req(REQ_READ); r.idx = 9'd2; send_req(r);
		r = rand_req(REQ_TICK); r.dt = 16'd1; send_req(r);
		r = rand_req(REQ_READ); r.idx = 9'd2; send_req(r);
		r = rand_req(REQ_SPAWN); send_req(r);

		// hold off until every expected result beat has come out
		while (pending != 0)
			@(negedge clk);

		// random mix
		repeat (560)
			send_kind(rand_kind());

		// fill the pool past full so the all-alive case lands on slot zero
		r = rand_req(REQ_TICK); r.dt = 16'hffff; send_req(r);
		r.dt = 16'hffff; send_req(r);
		repeat (POOL_SIZE + 8)
			send_kind(REQ_SPAWN);
		repeat (20)
			send_kind(REQ_READ);
		r = rand_req(REQ_TICK); r.dt = 16'd40000; send_req(r);
		repeat (10)
			send_kind(rand_kind());

		// tail with no idling on either side
		quiet = 1'b1;
		repeat (45)
			send_kind(rand_kind());

		while (pending != 0)
			@(negedge clk);
		waited = 0;
		while (waited < 50) begin
			@(negedge clk);
			waited++;
		end
		if (fail_count == 0 && pending == 0)
			$display("particle_pool_update_unit: match");
		else
			$display("particle_pool_update_unit: mismatch");
		$finish;
	end
endmodule
